@@ rtl/impedance_ratio_mag_phase_defines.svh @@
// Assertion macros for the impedance ratio block.
`ifndef IMPEDANCE_RATIO_MAG_PHASE_DEFINES_SVH
`define IMPEDANCE_RATIO_MAG_PHASE_DEFINES_SVH
// implication checked every clock outside reset
`define IRMP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define IRMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/irmp_pkg.sv @@
// Shared types, constants and tables for the impedance ratio block.
`timescale 1ns / 1ps
package irmp_pkg;
    localparam int CODE_BITS_DEF = 18;
    localparam int CORDIC_ITER_DEF = 16;
    localparam int CODE_W = 18;
    localparam int MAG_W = 32;
    localparam int PH_W = 16;
    localparam int ANG_W = 28;
    localparam int ATAN_N = 24;
    localparam int PHASE_LIMIT = 11520;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W = 73;
    localparam int IN_TDATA_W = 80;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;
    // working widths: MX_W 48 bits for the magnitude and phase lanes, PX_W 44 bits
    localparam int MX_W = 48;
    localparam int PX_W = 44;

    typedef enum logic [1:0] {
        CFG_LOAD_GAIN = 2'd0,
        CFG_RTIA_GAIN = 2'd1,
        CFG_RCAL      = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CORDIC, ST_DIV, ST_MUL, ST_FINISH, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [4:0] iter;
    } lane_ctl_t;

    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
        case (i)
            5'd0: atan_lut = 28'sd1474560; 5'd1: atan_lut = 28'sd870484;
            5'd2: atan_lut = 28'sd459940;  5'd3: atan_lut = 28'sd233473;
            5'd4: atan_lut = 28'sd117189;  5'd5: atan_lut = 28'sd58652;
            5'd6: atan_lut = 28'sd29333;   5'd7: atan_lut = 28'sd14667;
            5'd8: atan_lut = 28'sd7334;    5'd9: atan_lut = 28'sd3667;
            5'd10: atan_lut = 28'sd1833;   5'd11: atan_lut = 28'sd917;
            5'd12: atan_lut = 28'sd458;    5'd13: atan_lut = 28'sd229;
            5'd14: atan_lut = 28'sd115;    5'd15: atan_lut = 28'sd57;
            5'd16: atan_lut = 28'sd29;     5'd17: atan_lut = 28'sd14;
            5'd18: atan_lut = 28'sd7;      5'd19: atan_lut = 28'sd4;
            5'd20: atan_lut = 28'sd2;      5'd21: atan_lut = 28'sd1;
            default: atan_lut = '0;
        endcase
    endfunction

    // doubled PGA gain; index above four acts as four
    function automatic logic [4:0] gain_lut(input logic [2:0] sel);
        case (sel)
            3'd0: gain_lut = 5'd2;
            3'd1: gain_lut = 5'd3;
            3'd2: gain_lut = 5'd4;
            3'd3: gain_lut = 5'd8;
            default: gain_lut = 5'd18;
        endcase
    endfunction
endpackage

@@ rtl/impedance_ratio_mag_phase.sv @@
// Top level: ratiometric impedance magnitude and phase.
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid/s_tready    | s_tdata: load re, load im, rtia re,
//          |     |                      |   rtia im codes; s_tuser: mode
//  m_      | out | m_tvalid/m_tready    | m_tdata: magnitude, phase; m_tuser: err, mode
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
// Three CORDIC lanes (load, rtia, phase) load in the first CORDIC state after the input
// transaction and run ITER rotations, then a 64-bit serial divide and a product of the
// low, then the high quotient half on one 32x32 multiplier, then a finish state.
// Reset is synchronous; cal state clears to zero. One item in flight; s_tready
// drops until the result transaction completes (a result stall holds off input).
`timescale 1ns / 1ps
module impedance_ratio_mag_phase #(
    parameter int CODE_BITS = irmp_pkg::CODE_BITS_DEF,
    parameter int CORDIC_ITERATIONS = irmp_pkg::CORDIC_ITER_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // load re[17:0], load im[35:18], rtia re[53:36], rtia im[71:54], zero fill
    input  logic [irmp_pkg::IN_TDATA_W-1:0] s_tdata,
    // mode[0]
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // magnitude[31:0], phase[47:32]
    output logic [irmp_pkg::OUT_TDATA_W-1:0] m_tdata,
    // error[0] (divide error or zero real part), mode_echo[1]
    output logic [irmp_pkg::OUT_TUSER_W-1:0] m_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [irmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import irmp_pkg::*;
    `include "impedance_ratio_mag_phase_defines.svh"

    state_t state_reg, state_next;
    logic [4:0] iter_reg, iter_next;
    logic [2:0] lg_reg, rg_reg;
    logic [15:0] rcal_reg;
    logic [MAG_W-1:0] calm_reg;
    logic signed [PH_W-1:0] calp_reg;
    logic mode_reg;
    logic signed [CODE_BITS-1:0] lr_reg, li_reg, rr_reg, ri_reg;
    logic [MAG_W-1:0] mag_reg;
    logic signed [PH_W+1:0] ph_reg;
    logic err_reg, derr_reg;
    logic [63:0] prod_reg;

    logic in_acc, out_acc;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lg_reg <= '0; rg_reg <= '0; rcal_reg <= 16'd200;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LOAD_GAIN: lg_reg <= cfg_data[2:0];
                CFG_RTIA_GAIN: rg_reg <= cfg_data[2:0];
                CFG_RCAL: rcal_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // gains and lane inputs
    logic [4:0] gl, gr;
    assign gl = gain_lut(lg_reg);
    assign gr = gain_lut(rg_reg);
    logic signed [MX_W-1:0] l_x, l_y, r_x, r_y, p_x, p_y, p_sx, p_sy;
    always_comb begin
        l_x = MX_W'(lr_reg) <<< 4; l_y = MX_W'(li_reg) <<< 4;
        r_x = MX_W'(rr_reg) <<< 4; r_y = MX_W'(ri_reg) <<< 4;
        p_x = MX_W'(lr_reg) * $signed({1'b0, gr}) + MX_W'(rr_reg) * $signed({1'b0, gl});
        p_y = MX_W'(li_reg) * $signed({1'b0, gr}) + MX_W'(ri_reg) * $signed({1'b0, gl});
    end
    // normalize by leading-bit count so one part reaches 2^40
    function automatic logic [5:0] nshift(input logic signed [MX_W-1:0] x,
                                          input logic signed [MX_W-1:0] y);
        logic [MX_W-1:0] ax, ay, o;
        logic [5:0] s;
        ax = x[MX_W-1] ? -x : x;
        ay = y[MX_W-1] ? -y : y;
        o = ax | ay;
        s = 6'd0;
        for (int k = 0; k < 41; k++)
            if (o[k]) s = 6'(40 - k);
        if (|o[MX_W-1:40]) s = 6'd0;
        return s;
    endfunction
    logic [5:0] sh;
    assign sh = nshift(p_x, p_y);
    assign p_sx = p_x <<< sh;
    assign p_sy = p_y <<< sh;

    // lanes load on the first CORDIC cycle, then rotate with index iter-1
    lane_ctl_t lctl;
    assign lctl.start = (state_reg == ST_CORDIC) && (iter_reg == 5'd0);
    assign lctl.iter = iter_reg - 5'd1;

    logic signed [MX_W-1:0] ml, mr, px_unused;
    logic signed [ANG_W-1:0] zl_unused, zr_unused, zp;
    irmp_cordic_lane #(.W(MX_W), .ITER(CORDIC_ITERATIONS)) u_lane_load (
        .aclk, .ctl(lctl), .x_in(l_x), .y_in(l_y), .x_out(ml), .z_out(zl_unused));
    irmp_cordic_lane #(.W(MX_W), .ITER(CORDIC_ITERATIONS)) u_lane_rtia (
        .aclk, .ctl(lctl), .x_in(r_x), .y_in(r_y), .x_out(mr), .z_out(zr_unused));
    irmp_cordic_lane #(.W(MX_W), .ITER(CORDIC_ITERATIONS)) u_lane_phase (
        .aclk, .ctl(lctl), .x_in(p_sx), .y_in(p_sy), .x_out(px_unused), .z_out(zp));

    // merge: ratio operands
    logic signed [MX_W-1:0] num_s, den_s;
    always_comb begin
        num_s = mode_reg ? ml * $signed({1'b0, gr}) : mr * $signed({1'b0, gl});
        den_s = mode_reg ? mr * $signed({1'b0, gl}) : ml * $signed({1'b0, gr});
    end
    logic div_start, div_done;
    logic [63:0] quo;
    assign div_start = (state_reg == ST_CORDIC) && (state_next == ST_DIV);
    irmp_divider #(.NW(64), .DW(MX_W)) u_div (
        .aclk, .start(div_start), .num({num_s[MX_W-1:0], 16'd0}),
        .den(den_s), .quo(quo), .done(div_done));

    // factor*q on one 32x32 multiplier: low quotient half, then high half
    logic [MAG_W-1:0] fac;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [64:0] mag_sum;
    logic mag_sat;
    assign fac = mode_reg ? calm_reg : {8'd0, rcal_reg, 8'd0};
    assign mul_b = (state_reg == ST_MUL) ? quo[63:32] : quo[31:0];
    assign mul_p = 64'(fac) * 64'(mul_b);
    assign mag_sum = 65'(prod_reg) + 65'({mul_p[15:0], 32'd0});
    assign mag_sat = (|mul_p[63:16]) || (|mag_sum[64:48]);

    logic xzero_reg, ypos_reg;
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            mode_reg <= s_tuser;
            lr_reg <= s_tdata[CODE_BITS-1:0];
            li_reg <= s_tdata[CODE_W+CODE_BITS-1:CODE_W];
            rr_reg <= s_tdata[2*CODE_W+CODE_BITS-1:2*CODE_W];
            ri_reg <= s_tdata[3*CODE_W+CODE_BITS-1:3*CODE_W];
        end
        if (lctl.start) begin
            xzero_reg <= (p_x == '0);
            ypos_reg <= !p_y[MX_W-1];
        end
        if (div_start) derr_reg <= (den_s <= 0);
        if (state_reg == ST_DIV && div_done) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_MUL) begin
            mag_reg <= (derr_reg || mag_sat) ? 32'hFFFFFFFF : mag_sum[47:16];
        end
    end

    logic signed [PH_W+1:0] ph_raw;
    logic signed [ANG_W-1:0] zr;
    assign zr = (zp + 28'sd128) >>> 8;
    always_comb begin
        if (xzero_reg) ph_raw = ypos_reg ? 18'sd11520 : -18'sd11520;
        else if (zr > 28'sd11520) ph_raw = 18'sd11520;
        else if (zr < -28'sd11520) ph_raw = -18'sd11520;
        else ph_raw = zr[PH_W+1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calm_reg <= '0; calp_reg <= '0;
        end else if (state_reg == ST_FINISH) begin
            if (!mode_reg) begin
                calm_reg <= derr_reg ? 32'hFFFFFFFF : mag_reg;
                calp_reg <= ph_raw[PH_W-1:0];
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH) begin
            ph_reg <= mode_reg ? ph_raw - 18'(calp_reg) : ph_raw;
            err_reg <= derr_reg || xzero_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; iter_reg <= '0;
        end else begin
            state_reg <= state_next; iter_reg <= iter_next;
        end
    end
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_CORDIC;
            ST_CORDIC: if (32'(iter_reg) == CORDIC_ITERATIONS + 1) state_next = ST_DIV;
            ST_DIV: if (div_done && !div_start) state_next = ST_MUL;
            ST_MUL: state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT: if (out_acc) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end
    always_comb begin
        iter_next = '0;
        if (state_reg == ST_CORDIC && 32'(iter_reg) < CORDIC_ITERATIONS + 1)
            iter_next = iter_reg + 1'b1;
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {ph_reg[PH_W-1:0], mag_reg};
    assign m_tuser = {mode_reg, err_reg};

    `IRMP_ASSERT_IMP(a_one_item, m_tvalid, !s_tready, "input taken while result pending")
    `IRMP_ASSERT_NEXT(a_accept_starts, in_acc, state_reg == ST_CORDIC, "accept did not start")
    `IRMP_ASSERT_IMP(a_err_sat, m_tvalid && derr_reg, m_tdata[31:0] == 32'hFFFFFFFF,
        "divide error without saturation")
endmodule

@@ rtl/irmp_cordic_lane.sv @@
// One vectoring CORDIC lane, one rotation per cycle.
`timescale 1ns / 1ps
module irmp_cordic_lane #(
    parameter int W = 48,
    parameter int ITER = 16
) (
    input  logic aclk,
    input  irmp_pkg::lane_ctl_t ctl,
    input  logic signed [W-1:0] x_in,
    input  logic signed [W-1:0] y_in,
    output logic signed [W-1:0] x_out,
    output logic signed [irmp_pkg::ANG_W-1:0] z_out
);
    import irmp_pkg::*;
    logic signed [W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic signed [W-1:0] dx, dy;

    assign dx = y_reg >>> ctl.iter;
    assign dy = x_reg >>> ctl.iter;

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            // fold into right half plane
            x_reg <= x_in[W-1] ? -x_in : x_in;
            y_reg <= x_in[W-1] ? -y_in : y_in;
            z_reg <= '0;
        end else if (32'(ctl.iter) < ITER) begin
            if (!y_reg[W-1]) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_lut(ctl.iter);
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_lut(ctl.iter);
            end
        end
    end
    assign x_out = x_reg;
    assign z_out = z_reg;
endmodule

@@ rtl/irmp_divider.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module irmp_divider #(
    parameter int NW = 64,
    parameter int DW = 48
) (
    input  logic aclk,
    input  logic start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic done
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0] r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0] trial;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
            cnt_reg <= CW'(NW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (trial >= {1'b0, d_reg}) begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end else begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end
    assign quo = q_reg;
    assign done = (cnt_reg == '0);
endmodule
